/* hdl/ctp_pkg.sv */
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants for the call tree profiler.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int unsigned POOL_ENTRIES = 2048;
  localparam int unsigned IDX_W = $clog2(POOL_ENTRIES);
  localparam int unsigned LINK_W = IDX_W + 1;

  // link value meaning no entry (all ones of the link width)
  localparam logic [LINK_W-1:0] NO_LINK = '1;

  typedef enum logic [1:0] {
    CMD_ENTER  = 2'd0,
    CMD_EXIT   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_READ = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_USER    = 2'd0,
    MODE_KERNEL  = 2'd1,
    MODE_ELAPSED = 2'd2,
    MODE_SAMPLE  = 2'd3
  } mode_t;

  typedef enum logic {
    REG_TIMING_MODE    = 1'b0,
    REG_FILTER_PROCESS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_ROOT_READ,
    FSM_WALK,
    FSM_ENTER_RD,
    FSM_ENTER_WR,
    FSM_EXIT_RD,
    FSM_READ_RD,
    FSM_OUT
  } fsm_t;

  // one pool entry as stored in memory
  typedef struct packed {
    logic [31:0]       pc;
    logic [31:0]       count;
    logic [63:0]       ntime;
    logic [IDX_W-1:0]  parent;
    logic [LINK_W-1:0] child;
    logic [LINK_W-1:0] sibling;
  } node_t;

  // widen an internal link to the 16-bit port form
  function automatic logic [15:0] link_out(input logic [LINK_W-1:0] l);
    link_out = (l == NO_LINK) ? 16'hffff : 16'(l);
  endfunction

endpackage

/* hdl/ctp_node_ram.sv */
// ----------------------------------------------------------------------------
// ctp_node_ram
// Single-port node pool memory with a registered read.
// ----------------------------------------------------------------------------
module ctp_node_ram (
  input  logic                    clk,
  input  logic [ctp_pkg::IDX_W-1:0] addr,
  input  logic                    we,
  input  ctp_pkg::node_t          wdata,
  output ctp_pkg::node_t          rdata
);
  import ctp_pkg::*;

  node_t mem [POOL_ENTRIES];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/call_tree_profiler_top.sv */
// ----------------------------------------------------------------------------
// call_tree_profiler_top
// Call-context tree profiler keeping its tree in one node memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | command, pc, pid, time sources
//  out_    | output    | out_valid / out_ready | status, node, read fields
//  cfg_    | input     | cfg_valid / cfg_ready | register index, data
//
// One request at a time over the single node memory port: exit reads the current
// entry and writes it back, finish stamps the root time, read fetches one entry,
// and ignored requests and bad reads go straight to the result. Entry reads the
// current entry and walks its child list; a new entry is written, then its parent
// is read and relinked; a full pool overflows. Reset writes the root entry first;
// no clearing pass. The next request waits until the result has been taken.
module call_tree_profiler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_call_pc,
  input  logic [15:0] in_process_id,
  input  logic signed [63:0] in_cycle_now,
  input  logic signed [63:0] in_proc_cycles,
  input  logic signed [63:0] in_kernel_cycles,
  input  logic signed [63:0] in_sample_clock,
  input  logic [10:0] in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [10:0] out_current_node,
  output logic [31:0] out_read_pc,
  output logic [31:0] out_read_count,
  output logic signed [63:0] out_read_time,
  output logic [15:0] out_read_child,
  output logic [15:0] out_read_sibling,
  output logic [31:0] out_error_count,
  output logic [10:0] out_last_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ctp_pkg::*;

  fsm_t state_r, state_nxt;
  logic              init_r, init_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [15:0]       filter_r, filter_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  free_r, free_nxt;
  logic              active_r, active_nxt;
  logic [31:0]       err_r, err_nxt;
  // latched request
  logic [1:0]        cmd_r, cmd_nxt;
  logic [31:0]       pc_r, pc_nxt;
  logic [63:0]       delta_r, delta_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LINK_W-1:0] cur_child_r, cur_child_nxt;
  // result register
  logic              ov_r, ov_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [31:0]       rpc_r, rpc_nxt, rcnt_r, rcnt_nxt;
  logic [63:0]       rtime_r, rtime_nxt;
  logic [15:0]       rch_r, rch_nxt, rsib_r, rsib_nxt;

  logic [IDX_W-1:0] m_addr;
  logic             m_we;
  node_t            m_wdata, m_rdata;
  logic             in_acc, accepted, have_free;
  logic [63:0]      delta_in;
  logic [LINK_W-1:0] walk_next;

  ctp_node_ram u_ram (
    .clk  (clk),
    .addr (m_addr),
    .we   (m_we),
    .wdata(m_wdata),
    .rdata(m_rdata)
  );

  assign in_ready  = (state_r == FSM_IDLE) && !init_r && !ov_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign accepted  = (filter_r == 16'd0) || (in_process_id == filter_r);
  assign have_free = ({1'b0, free_r} + 1'b1) < LINK_W'(POOL_ENTRIES);
  assign walk_next = m_rdata.sibling;

  // time delta chosen by mode
  always_comb begin
    case (mode_r)
      MODE_USER:    delta_in = in_cycle_now - in_kernel_cycles;
      MODE_KERNEL:  delta_in = in_cycle_now + in_proc_cycles;
      MODE_ELAPSED: delta_in = in_cycle_now;
      default:      delta_in = in_sample_clock;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FSM_IDLE;
      init_r   <= 1'b1;
      mode_r   <= 2'd0;
      filter_r <= 16'd0;
      cur_r    <= '0;
      free_r   <= '0;
      active_r <= 1'b1;
      err_r    <= 32'd0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      init_r   <= init_nxt;
      mode_r   <= mode_nxt;
      filter_r <= filter_nxt;
      cur_r    <= cur_nxt;
      free_r   <= free_nxt;
      active_r <= active_nxt;
      err_r    <= err_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    pc_r        <= pc_nxt;
    delta_r     <= delta_nxt;
    idx_r       <= idx_nxt;
    cur_child_r <= cur_child_nxt;
    st_r        <= st_nxt;
    rpc_r       <= rpc_nxt;
    rcnt_r      <= rcnt_nxt;
    rtime_r     <= rtime_nxt;
    rch_r       <= rch_nxt;
    rsib_r      <= rsib_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    init_nxt = 1'b0;
    mode_nxt = mode_r;
    filter_nxt = filter_r;
    cur_nxt = cur_r;
    free_nxt = free_r;
    active_nxt = active_r;
    err_nxt = err_r;
    ov_nxt = ov_r;
    cmd_nxt = cmd_r;
    pc_nxt = pc_r;
    delta_nxt = delta_r;
    idx_nxt = idx_r;
    cur_child_nxt = cur_child_r;
    st_nxt = st_r;
    rpc_nxt = rpc_r;
    rcnt_nxt = rcnt_r;
    rtime_nxt = rtime_r;
    rch_nxt = rch_r;
    rsib_nxt = rsib_r;
    m_addr = '0;
    m_we = 1'b0;
    m_wdata = '0;
    m_wdata.child = NO_LINK;
    m_wdata.sibling = NO_LINK;

    if (cfg_valid) begin
      if (cfg_index == REG_TIMING_MODE) mode_nxt = cfg_data[1:0];
      else filter_nxt = cfg_data;
    end
    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      FSM_IDLE: begin
        if (init_r) begin
          // write the root entry
          m_we = 1'b1;
        end else if (in_acc) begin
          cmd_nxt = in_command;
          pc_nxt = in_call_pc;
          delta_nxt = delta_in;
          idx_nxt = in_entry_index;
          st_nxt = ST_DONE;
          rpc_nxt = '0; rcnt_nxt = '0; rtime_nxt = '0; rch_nxt = '0; rsib_nxt = '0;
          if (in_command == CMD_READ) begin
            if (in_entry_index > free_r) begin
              st_nxt = ST_BAD_READ;
              state_nxt = FSM_OUT;
            end else begin
              m_addr = in_entry_index;
              state_nxt = FSM_READ_RD;
            end
          end else if (!accepted) begin
            st_nxt = ST_IGNORED;
            state_nxt = FSM_OUT;
          end else if (in_command == CMD_FINISH) begin
            m_addr = '0;
            active_nxt = 1'b0;
            state_nxt = FSM_ROOT_READ;
          end else if (!active_r) begin
            st_nxt = ST_IGNORED;
            state_nxt = FSM_OUT;
          end else begin
            m_addr = cur_r;
            state_nxt = (in_command == CMD_ENTER) ? FSM_ROOT_READ : FSM_EXIT_RD;
          end
        end
      end
      FSM_ROOT_READ: begin
        if (cmd_r == CMD_FINISH) begin
          // stamp root time
          m_addr = '0;
          m_we = 1'b1;
          m_wdata = m_rdata;
          m_wdata.ntime = delta_r;
          state_nxt = FSM_OUT;
        end else begin
          // current entry read; start the child walk
          cur_child_nxt = m_rdata.child;
          if (m_rdata.child == NO_LINK) begin
            state_nxt = FSM_ENTER_WR;
          end else begin
            m_addr = m_rdata.child[IDX_W-1:0];
            idx_nxt = m_rdata.child[IDX_W-1:0];
            state_nxt = FSM_WALK;
          end
        end
      end
      FSM_WALK: begin
        if (m_rdata.pc == pc_r) begin
          // match: bump and time the entry
          m_addr = idx_r;
          m_we = 1'b1;
          m_wdata = m_rdata;
          m_wdata.count = m_rdata.count + 32'd1;
          m_wdata.ntime = m_rdata.ntime - delta_r;
          cur_nxt = idx_r;
          state_nxt = FSM_OUT;
        end else if (walk_next == NO_LINK) begin
          state_nxt = FSM_ENTER_WR;
        end else begin
          m_addr = walk_next[IDX_W-1:0];
          idx_nxt = walk_next[IDX_W-1:0];
        end
      end
      FSM_ENTER_WR: begin
        if (!have_free) begin
          active_nxt = 1'b0;
          if (err_r != '1) err_nxt = err_r + 32'd1;
          st_nxt = ST_OVERFLOW;
          state_nxt = FSM_OUT;
        end else begin
          // new entry, then relink parent
          m_addr = free_r + 1'b1;
          m_we = 1'b1;
          m_wdata.pc = pc_r;
          m_wdata.count = 32'd1;
          m_wdata.ntime = 64'd0 - delta_r;
          m_wdata.parent = cur_r;
          m_wdata.child = NO_LINK;
          m_wdata.sibling = cur_child_r;
          idx_nxt = free_r + 1'b1;
          free_nxt = free_r + 1'b1;
          state_nxt = FSM_ENTER_RD;
        end
      end
      FSM_ENTER_RD: begin
        m_addr = cur_r;
        state_nxt = FSM_EXIT_RD;
        cmd_nxt = CMD_ENTER;
        st_nxt = ST_DONE;
      end
      FSM_EXIT_RD: begin
        m_addr = cur_r;
        m_we = 1'b1;
        m_wdata = m_rdata;
        if (cmd_r == CMD_ENTER) begin
          m_wdata.child = {1'b0, idx_r};
          cur_nxt = idx_r;
        end else begin
          m_wdata.ntime = m_rdata.ntime + delta_r;
          if (cur_r == '0) active_nxt = 1'b0;
          else cur_nxt = m_rdata.parent;
        end
        state_nxt = FSM_OUT;
      end
      FSM_READ_RD: begin
        rpc_nxt = m_rdata.pc;
        rcnt_nxt = m_rdata.count;
        rtime_nxt = m_rdata.ntime;
        rch_nxt = link_out(m_rdata.child);
        rsib_nxt = link_out(m_rdata.sibling);
        state_nxt = FSM_OUT;
      end
      FSM_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // outputs taken from result state; node and counters snapshot at load
  logic [IDX_W-1:0] onode_r, oused_r;
  logic [31:0]      oerr_r;
  logic [1:0]       ost_r;
  logic [31:0]      opc_r, ocnt_r;
  logic [63:0]      otime_r;
  logic [15:0]      och_r, osib_r;
  always_ff @(posedge clk) begin
    if (state_r == FSM_OUT && (!ov_r || out_ready)) begin
      onode_r <= cur_r;
      oused_r <= free_r;
      oerr_r  <= err_r;
      ost_r   <= st_r;
      opc_r   <= rpc_r;
      ocnt_r  <= rcnt_r;
      otime_r <= rtime_r;
      och_r   <= rch_r;
      osib_r  <= rsib_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_current_node = onode_r;
  assign out_read_pc      = opc_r;
  assign out_read_count   = ocnt_r;
  assign out_read_time    = otime_r;
  assign out_read_child   = och_r;
  assign out_read_sibling = osib_r;
  assign out_error_count  = oerr_r;
  assign out_last_used    = oused_r;

endmodule

/* hdl/ctp_checker.sv */
// ----------------------------------------------------------------------------
// ctp_checker
// Port-level checks on the call tree profiler, bound to the top level.
// ----------------------------------------------------------------------------
module ctp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [10:0] out_current_node,
  input logic [10:0] out_last_used,
  input logic [31:0] out_error_count
);
  import ctp_pkg::*;

  // no new request while a result is still pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken with result pending");

  // stalled result keeps its status
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  // current node never beyond last allocated entry
  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_current_node <= out_last_used)
    else $error("current node beyond allocated pool");

  // overflow reports a nonzero error count
  a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERFLOW |-> out_error_count != 32'd0)
    else $error("overflow without error count");

endmodule

bind call_tree_profiler_top ctp_checker u_ctp_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_status(out_status), .out_current_node(out_current_node),
  .out_last_used(out_last_used), .out_error_count(out_error_count)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the call tree profiler. A short stimulus table
// covers reset contents, field extremes, child-list walks, filtered requests
// and bad read indexes; random phases under every timing mode and several
// process filters follow. The run ends by filling the node pool up to the
// overflow and then checks finish and the inactive behavior. Every result is
// checked against a cycle-free tree model kept here.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 50;
  localparam logic [15:0] NONE = 16'hffff;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] pc;
    logic [15:0] pid;
    logic [63:0] cyc;
    logic [63:0] proc;
    logic [63:0] kern;
    logic [63:0] smp;
    logic [10:0] idx;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [10:0] node;
    logic [31:0] rpc;
    logic [31:0] rcount;
    logic [63:0] rtime;
    logic [15:0] rchild;
    logic [15:0] rsib;
    logic [31:0] errs;
    logic [10:0] last;
  } result_t;

  // table row: typed-in status and node where they are obvious
  typedef struct {
    req_t        rq;
    bit          typed;
    status_t     st;
    logic [10:0] node;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = '0;
  logic [31:0] in_call_pc = '0;
  logic [15:0] in_process_id = '0;
  logic signed [63:0] in_cycle_now = '0;
  logic signed [63:0] in_proc_cycles = '0;
  logic signed [63:0] in_kernel_cycles = '0;
  logic signed [63:0] in_sample_clock = '0;
  logic [10:0] in_entry_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [10:0] out_current_node;
  logic [31:0] out_read_pc;
  logic [31:0] out_read_count;
  logic signed [63:0] out_read_time;
  logic [15:0] out_read_child;
  logic [15:0] out_read_sibling;
  logic [31:0] out_error_count;
  logic [10:0] out_last_used;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  call_tree_profiler_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tree shadow and configuration
  logic [31:0] t_pc [POOL_ENTRIES];
  logic [31:0] t_count [POOL_ENTRIES];
  logic [63:0] t_time [POOL_ENTRIES];
  logic [10:0] t_parent [POOL_ENTRIES];
  logic [15:0] t_child [POOL_ENTRIES];
  logic [15:0] t_sib [POOL_ENTRIES];
  logic [10:0] cur_node = '0;
  logic [10:0] top_used = '0;
  bit          prof_on = 1'b1;
  logic [31:0] ovf_errs = '0;
  mode_t       cur_mode = MODE_USER;
  logic [15:0] cur_filter = '0;

  result_t expected_results [$];
  int      mismatches = 0;
  bit      idle_en = 1'b1;
  bit      pin_next = 1'b0;
  status_t pin_st;
  logic [10:0] pin_node;

  function automatic logic [63:0] time_delta(req_t r);
    case (cur_mode)
      MODE_USER:   return r.cyc - r.kern;
      MODE_KERNEL: return r.cyc + r.proc;
      MODE_ELAPSED: return r.cyc;
      default:     return r.smp;
    endcase
  endfunction

  // advance the tree shadow by one request, return its result
  function automatic result_t profile_step(req_t r);
    result_t res;
    logic [63:0] d;
    int p;
    int steps;
    bit found;
    bit ok;
    res = '0;
    res.status = ST_DONE;
    d = time_delta(r);
    ok = (cur_filter == 0) || (r.pid == cur_filter);
    if (r.cmd == CMD_READ) begin
      if (r.idx > top_used) begin
        res.status = ST_BAD_READ;
      end else begin
        res.rpc = t_pc[r.idx];
        res.rcount = t_count[r.idx];
        res.rtime = t_time[r.idx];
        res.rchild = t_child[r.idx];
        res.rsib = t_sib[r.idx];
      end
    end else if (!ok) begin
      res.status = ST_IGNORED;
    end else if (r.cmd == CMD_FINISH) begin
      t_time[0] = d;
      prof_on = 1'b0;
    end else if (!prof_on) begin
      res.status = ST_IGNORED;
    end else if (r.cmd == CMD_ENTER) begin
      p = t_child[cur_node];
      found = 1'b0;
      steps = 0;
      while (p != NONE && steps < POOL_ENTRIES) begin
        if (t_pc[p] == r.pc) begin
          found = 1'b1;
          break;
        end
        p = t_sib[p];
        steps++;
      end
      if (!found) begin
        if (int'(top_used) + 1 >= POOL_ENTRIES) begin
          prof_on = 1'b0;
          if (ovf_errs != 32'hffffffff) ovf_errs++;
          res.status = ST_OVERFLOW;
        end else begin
          p = int'(top_used) + 1;
          top_used = 11'(p);
          t_sib[p] = t_child[cur_node];
          t_child[cur_node] = 16'(p);
          t_pc[p] = r.pc;
          t_parent[p] = cur_node;
          t_child[p] = NONE;
          t_count[p] = '0;
          t_time[p] = '0;
          found = 1'b1;
        end
      end
      if (found) begin
        cur_node = 11'(p);
        t_count[p]++;
        t_time[p] -= d;
      end
    end else begin
      t_time[cur_node] += d;
      if (cur_node == 0) prof_on = 1'b0;
      else cur_node = t_parent[cur_node];
    end
    res.node = cur_node;
    res.errs = ovf_errs;
    res.last = top_used;
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t rand_times(req_t r);
    r.cyc = rand64();
    r.proc = rand64();
    r.kern = rand64();
    r.smp = rand64();
    return r;
  endfunction

  task automatic idle_burst();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // send one request and record its expected result at acceptance
  task automatic send_request(req_t r);
    result_t res;
    idle_burst();
    in_valid <= 1'b1;
    in_command <= r.cmd;
    in_call_pc <= r.pc;
    in_process_id <= r.pid;
    in_cycle_now <= r.cyc;
    in_proc_cycles <= r.proc;
    in_kernel_cycles <= r.kern;
    in_sample_clock <= r.smp;
    in_entry_index <= r.idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = profile_step(r);
    if (pin_next) begin
      res.status = pin_st;
      res.node = pin_node;
      pin_next = 1'b0;
    end
    expected_results.push_back(res);
  endtask

  // register write, only once the block has drained
  task automatic write_reg(reg_idx_t idx, logic [15:0] data);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TIMING_MODE) cur_mode = mode_t'(data[1:0]);
    else cur_filter = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t mk(cmd_t c, logic [31:0] pc, logic [15:0] pid, logic [63:0] t,
                              logic [10:0] idx, bit typed, status_t st, logic [10:0] node);
    row_t w;
    w.rq.cmd = c;
    w.rq.pc = pc;
    w.rq.pid = pid;
    w.rq.cyc = t;
    w.rq.proc = ~t;
    w.rq.kern = t ^ 64'h5555_5555_5555_5555;
    w.rq.smp = -t;
    w.rq.idx = idx;
    w.typed = typed;
    w.st = st;
    w.node = node;
    return w;
  endfunction

  // random request for the profiling phases
  function automatic req_t rand_request();
    req_t r;
    int k;
    r = rand_times('{default: '0, cmd: CMD_READ});
    r.pid = (cur_filter == 0 || $urandom_range(0, 9) == 0) ? 16'($urandom) : cur_filter;
    r.pc = ($urandom_range(0, 99) < 93) ? 32'($urandom_range(0, 7)) : $urandom;
    r.idx = ($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(0, top_used));
    k = $urandom_range(0, 99);
    if (k < 50) r.cmd = CMD_ENTER;
    else if (k < 78) r.cmd = (cur_node == 0) ? CMD_ENTER : CMD_EXIT;
    else r.cmd = CMD_READ;
    return r;
  endfunction

  // result side stalls
  initial begin
    @(posedge rst_n);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // result checker and watchdog
  initial begin
    result_t got;
    result_t want;
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || !rst_n) quiet = 0;
      else quiet++;
      if (rst_n && out_valid && out_ready) begin
        quiet = 0;
        got.status = status_t'(out_status);
        got.node = out_current_node;
        got.rpc = out_read_pc;
        got.rcount = out_read_count;
        got.rtime = out_read_time;
        got.rchild = out_read_child;
        got.rsib = out_read_sibling;
        got.errs = out_error_count;
        got.last = out_last_used;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected: %p", want);
              $display("  actual:   %p", got);
            end
          end
        end
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    row_t rows [$];
    req_t r;
    logic [15:0] filters [RAND_PHASES];
    int n;

    t_pc[0] = '0;
    t_count[0] = '0;
    t_time[0] = '0;
    t_parent[0] = '0;
    t_child[0] = NONE;
    t_sib[0] = NONE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset contents, extremes and child-list walks
    rows.push_back(mk(CMD_READ, 32'h0, 16'h0, 64'h0, 11'd0, 1, ST_DONE, 11'd0));
    rows.push_back(mk(CMD_READ, 32'h0, 16'h0, 64'h0, 11'd1, 1, ST_BAD_READ, 11'd0));
    rows.push_back(mk(CMD_READ, 32'h0, 16'hffff, 64'h0, 11'd2047, 1, ST_BAD_READ, 11'd0));
    rows.push_back(mk(CMD_ENTER, 32'hffffffff, 16'hffff, 64'h7fffffffffffffff, 11'd2047,
                      1, ST_DONE, 11'd1));
    rows.push_back(mk(CMD_ENTER, 32'h0, 16'h0, 64'h8000000000000000, 11'd0, 1, ST_DONE, 11'd2));
    rows.push_back(mk(CMD_EXIT, 32'h0, 16'h1234, 64'hffffffffffffffff, 11'd0, 1, ST_DONE, 11'd1));
    rows.push_back(mk(CMD_ENTER, 32'h0, 16'h0, 64'h1, 11'd0, 1, ST_DONE, 11'd2));
    rows.push_back(mk(CMD_EXIT, 32'h0, 16'h0, 64'h7fffffffffffffff, 11'd0, 1, ST_DONE, 11'd1));
    rows.push_back(mk(CMD_ENTER, 32'h12345678, 16'h0, 64'h10, 11'd0, 1, ST_DONE, 11'd3));
    rows.push_back(mk(CMD_EXIT, 32'h0, 16'h0, 64'h20, 11'd0, 1, ST_DONE, 11'd1));
    rows.push_back(mk(CMD_ENTER, 32'h0, 16'h0, 64'h30, 11'd0, 1, ST_DONE, 11'd2));
    rows.push_back(mk(CMD_EXIT, 32'h0, 16'h0, 64'h40, 11'd0, 1, ST_DONE, 11'd1));
    rows.push_back(mk(CMD_READ, 32'h0, 16'h0, 64'h0, 11'd1, 0, ST_DONE, 11'd0));
    rows.push_back(mk(CMD_READ, 32'h0, 16'h0, 64'h0, 11'd2, 0, ST_DONE, 11'd0));
    rows.push_back(mk(CMD_READ, 32'h0, 16'h0, 64'h0, 11'd3, 0, ST_DONE, 11'd0));
    rows.push_back(mk(CMD_READ, 32'h0, 16'h0, 64'h0, 11'd4, 1, ST_BAD_READ, 11'd1));
    foreach (rows[i]) begin
      pin_next = rows[i].typed;
      pin_st = rows[i].st;
      pin_node = rows[i].node;
      send_request(rows[i].rq);
    end

    // filtered process
    write_reg(REG_FILTER_PROCESS, 16'd5);
    rows.delete();
    rows.push_back(mk(CMD_ENTER, 32'h7, 16'd6, 64'h5, 11'd0, 1, ST_IGNORED, 11'd1));
    rows.push_back(mk(CMD_FINISH, 32'h0, 16'd4, 64'h5, 11'd0, 1, ST_IGNORED, 11'd1));
    rows.push_back(mk(CMD_READ, 32'h0, 16'd6, 64'h0, 11'd2, 0, ST_DONE, 11'd0));
    rows.push_back(mk(CMD_EXIT, 32'h0, 16'd5, 64'h9, 11'd0, 1, ST_DONE, 11'd0));
    rows.push_back(mk(CMD_ENTER, 32'h0, 16'd5, 64'h11, 11'd0, 0, ST_DONE, 11'd0));
    foreach (rows[i]) begin
      pin_next = rows[i].typed;
      pin_st = rows[i].st;
      pin_node = rows[i].node;
      send_request(rows[i].rq);
    end

    // random phases, one setting each
    filters = '{16'h0, 16'($urandom_range(1, 65534)), 16'hffff, 16'h0, 16'h0,
                16'($urandom_range(1, 65534))};
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(REG_TIMING_MODE, {14'($urandom), 2'(ph % 4)});
      write_reg(REG_FILTER_PROCESS, filters[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(rand_request());
    end

    // fill the pool until it overflows, no idling from here on
    idle_en = 1'b0;
    write_reg(REG_TIMING_MODE, 16'(MODE_ELAPSED));
    write_reg(REG_FILTER_PROCESS, 16'h0);
    n = 0;
    while (prof_on) begin
      r = rand_times('{default: '0, cmd: CMD_ENTER});
      r.pc = 32'hc0000000 | 32'(n);
      r.pid = 16'($urandom);
      send_request(r);
      n++;
    end

    // inactive profiling, finish twice under two modes, final reads
    r = rand_times('{default: '0, cmd: CMD_ENTER});
    send_request(r);
    r = rand_times('{default: '0, cmd: CMD_EXIT});
    send_request(r);
    r = rand_times('{default: '0, cmd: CMD_FINISH});
    send_request(r);
    write_reg(REG_TIMING_MODE, 16'(MODE_KERNEL));
    r = rand_times('{default: '0, cmd: CMD_FINISH});
    send_request(r);
    foreach (filters[i]) begin
      r = rand_times('{default: '0, cmd: CMD_READ});
      r.idx = (i == 0) ? 11'd0 : (i == 1) ? 11'd2047 : 11'($urandom);
      send_request(r);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* call_tree_profiler_top.f */
hdl/ctp_pkg.sv
hdl/ctp_node_ram.sv
hdl/call_tree_profiler_top.sv
hdl/ctp_checker.sv
bench/testbench.sv
